// ----- src/bblur_pkg.sv -----
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared constants, types and state codes of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int PIX_BITS         = 8;    // channel width on the ports
  localparam int CH_MAX_BITS      = 16;   // widest internal channel
  localparam int NUM_CH           = 3;
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int CHANNEL_BITS_DEF = 8;

  localparam int CFG_IDX_BITS     = 2;
  localparam int CFG_DATA_BITS    = 16;
  localparam int WIDTH_REG_BITS   = 11;
  localparam int HEIGHT_REG_BITS  = 13;
  localparam int RESET_WIDTH      = 640;
  localparam int RESET_HEIGHT     = 480;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

  // entries of the front-to-back queue, power of two
  localparam int QDEPTH = 2;

  // what the front found out about one item
  typedef struct packed {
    logic top_ok;   // row above the center is inside the frame
    logic bot_ok;   // row below the center is inside the frame
    logic emit_a;   // result for the column left of the current one
    logic emit_b;   // extra result for the last column of the row
    logic col0_ok;  // oldest window column is inside the frame
    logic col1_ok;  // middle window column is inside the frame
    logic eof_b;    // extra result is the frame's last pixel
  } op_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_COLSUM,
    ST_ACC,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } back_state_t;

endpackage

// ----- src/bblur_in_if.sv -----
// ----------------------------------------------------------------------------
// bblur_in_if
// Pixel input channel: command and three channel values.
// ----------------------------------------------------------------------------
interface bblur_in_if;
  import bblur_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [PIX_BITS-1:0] red_in;
  logic [PIX_BITS-1:0] green_in;
  logic [PIX_BITS-1:0] blue_in;

  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

// ----- src/bblur_out_if.sv -----
// ----------------------------------------------------------------------------
// bblur_out_if
// Result channel: blurred channels and burst / frame markers.
// ----------------------------------------------------------------------------
interface bblur_out_if;
  import bblur_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIX_BITS-1:0] red_out;
  logic [PIX_BITS-1:0] green_out;
  logic [PIX_BITS-1:0] blue_out;
  logic                last_in_burst;
  logic                end_of_frame;

  modport source (output valid, red_out, green_out, blue_out, last_in_burst,
                  end_of_frame, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last_in_burst,
                  end_of_frame, output ready);
endinterface

// ----- src/bblur_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bblur_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bblur_cfg_if;
  import bblur_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/bblur_front.sv -----
// ----------------------------------------------------------------------------
// bblur_front
// Accepts items, tracks column and row, classifies each item and pushes its
// work into the queue, bar stray drain items. Holds the frame size registers.
// ----------------------------------------------------------------------------
module bblur_front #(
  parameter int MAX_WIDTH    = bblur_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bblur_pkg::CHANNEL_BITS_DEF,
  parameter int CW           = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  bblur_in_if.sink                              in_px,
  bblur_cfg_if.sink                             cfg_wr,
  input  logic                                  q_full,
  output logic                                  push,
  output bblur_pkg::op_flags_t                  push_flags,
  output logic [CW-1:0]                         push_col,
  output logic [bblur_pkg::NUM_CH*CHANNEL_BITS-1:0] push_pix
);
  import bblur_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = HEIGHT_REG_BITS;

  function automatic logic [WW-1:0] clamp_w(input logic [WIDTH_REG_BITS-1:0] v);
    logic [WW-1:0] res;
    if (v == '0) begin
      res = WW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      res = WW'(MAX_WIDTH);
    end else begin
      res = WW'(v);
    end
    return res;
  endfunction

  function automatic logic [RW-1:0] clamp_h(input logic [RW-1:0] v);
    return (v == '0) ? RW'(1) : v;
  endfunction

  logic [WW-1:0] eff_w_r, eff_w_nxt;
  logic [RW-1:0] eff_h_r, eff_h_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic          cfg_fire;
  logic          in_fire;
  logic          drain;
  logic          skip;
  logic [CW-1:0] col_eff;
  logic [CW:0]   col_ext;
  logic [CW:0]   col_inc;
  logic          at_end;
  logic [CH_MAX_BITS-1:0] red_ext, green_ext, blue_ext;

  assign cfg_wr.ready = 1'b1;
  assign in_px.ready  = !q_full;

  assign cfg_fire = cfg_wr.valid && cfg_wr.ready;
  assign in_fire  = in_px.valid && in_px.ready;

  assign drain   = (row_r >= eff_h_r);
  assign skip    = !drain && in_px.cmd;
  assign col_eff = (col_r >= eff_w_r) ? '0 : col_r;
  assign col_ext = (CW+1)'(col_eff);
  assign col_inc = col_ext + (CW+1)'(1);
  assign at_end  = (col_inc >= (CW+1)'(eff_w_r));

  // classify the item
  always_comb begin
    push_flags.top_ok  = (row_r >= RW'(2));
    push_flags.bot_ok  = !drain;
    push_flags.emit_a  = (row_r != '0) && (col_ext != '0);
    push_flags.emit_b  = (row_r != '0) && at_end;
    push_flags.col0_ok = (col_ext >= (CW+1)'(2));
    push_flags.col1_ok = (col_ext != '0);
    push_flags.eof_b   = drain;
  end

  assign red_ext   = CH_MAX_BITS'(in_px.red_in);
  assign green_ext = CH_MAX_BITS'(in_px.green_in);
  assign blue_ext  = CH_MAX_BITS'(in_px.blue_in);

  assign push     = in_fire && !skip;
  assign push_col = col_eff;
  assign push_pix = drain ? '0 : {red_ext[CHANNEL_BITS-1:0],
                                  green_ext[CHANNEL_BITS-1:0],
                                  blue_ext[CHANNEL_BITS-1:0]};

  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (cfg_fire) begin
      if (cfg_wr.index == REG_IMAGE_WIDTH) begin
        eff_w_nxt = clamp_w(cfg_wr.data[WIDTH_REG_BITS-1:0]);
        col_nxt   = '0;
        row_nxt   = '0;
      end else if (cfg_wr.index == REG_IMAGE_HEIGHT) begin
        eff_h_nxt = clamp_h(cfg_wr.data[RW-1:0]);
        col_nxt   = '0;
        row_nxt   = '0;
      end
    end else if (push) begin
      if (at_end) begin
        col_nxt = '0;
        row_nxt = drain ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= clamp_w(WIDTH_REG_BITS'(RESET_WIDTH));
      eff_h_r <= RW'(RESET_HEIGHT);
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

// ----- src/bblur_queue.sv -----
// ----------------------------------------------------------------------------
// bblur_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bblur_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import bblur_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int NW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full  = (count_r == NW'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

// ----- src/bblur_back.sv -----
// ----------------------------------------------------------------------------
// bblur_back
// Line stores, 3x3 window and the mean unit. Takes one queued item at a
// time, shifts the window and produces up to two results.
// ----------------------------------------------------------------------------
module bblur_back #(
  parameter int MAX_WIDTH    = bblur_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bblur_pkg::CHANNEL_BITS_DEF,
  parameter int CW           = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      q_empty,
  output logic                                      q_pop,
  input  bblur_pkg::op_flags_t                      h_flags,
  input  logic [CW-1:0]                             h_col,
  input  logic [bblur_pkg::NUM_CH*CHANNEL_BITS-1:0] h_pix,
  bblur_out_if.source                               out_px
);
  import bblur_pkg::*;

  localparam int CB  = CHANNEL_BITS;
  localparam int PXW = NUM_CH * CB;
  localparam int CSW = CB + 2;          // one window column, three rows
  localparam int SB  = CB + 4;          // sum of up to nine samples plus half
  localparam int PB  = 2 * SB + 1;      // numerator times reciprocal
  localparam int FW  = SB + 5;          // quotient times divisor
  localparam int RCP_1 = 1 << SB;
  localparam int RCP_2 = (1 << SB) / 2;
  localparam int RCP_3 = (1 << SB) / 3;
  localparam int RCP_4 = (1 << SB) / 4;
  localparam int RCP_6 = (1 << SB) / 6;
  localparam int RCP_9 = (1 << SB) / 9;

  back_state_t state_r, state_nxt;

  logic [PXW-1:0] older_mem [MAX_WIDTH];
  logic [PXW-1:0] newer_mem [MAX_WIDTH];

  op_flags_t      flags_r;
  logic [CW-1:0]  col_r;
  logic [PXW-1:0] pix_r;
  logic [PXW-1:0] older_rd_r;
  logic [PXW-1:0] newer_rd_r;
  logic           sel_b_r;

  logic [CB-1:0]  win_r    [3][3][NUM_CH];  // [row][column][channel]
  logic [CSW-1:0] colsum_r [3][NUM_CH];     // [column][channel]
  logic [SB-1:0]  numer_r  [NUM_CH];
  logic [SB-1:0]  numer_nxt[NUM_CH];
  logic [3:0]     d_r, d_nxt;
  logic [PB-1:0]  prod_r   [NUM_CH];
  logic [CB-1:0]  res_r    [NUM_CH];
  logic [CB-1:0]  res_nxt  [NUM_CH];
  logic           last_r, eof_r;

  logic [1:0]     rows_in, cols_in;
  logic [2:0]     col_mask;
  logic [SB:0]    rcp;
  logic [SB:0]    q0   [NUM_CH];
  logic [SB:0]    q1   [NUM_CH];
  logic [FW-1:0]  qd   [NUM_CH];
  logic [FW-1:0]  rem  [NUM_CH];
  logic           out_fire;
  logic           more_b;
  logic [CH_MAX_BITS-1:0] res_ext [NUM_CH];

  assign out_fire = out_px.valid && out_px.ready;
  assign more_b   = !sel_b_r && flags_r.emit_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (!q_empty) state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = ST_COLSUM;
      ST_COLSUM: state_nxt = (flags_r.emit_a || flags_r.emit_b) ? ST_ACC : ST_IDLE;
      ST_ACC:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_FIX;
      ST_FIX:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = more_b ? ST_ACC : ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    q_pop        = 1'b0;
    out_px.valid = 1'b0;
    case (state_r)
      ST_IDLE: q_pop        = !q_empty;
      ST_OUT:  out_px.valid = 1'b1;
      default: begin
        q_pop        = 1'b0;
        out_px.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // line stores: read at pop, write back when the window shifts
  always_ff @(posedge clk) begin
    if (q_pop) begin
      older_rd_r <= older_mem[h_col];
      newer_rd_r <= newer_mem[h_col];
    end
    if (state_r == ST_SHIFT) begin
      older_mem[col_r] <= newer_rd_r;
      newer_mem[col_r] <= pix_r;
    end
  end

  // samples that count for the result in progress
  always_comb begin
    rows_in  = 2'd1 + 2'(flags_r.top_ok) + 2'(flags_r.bot_ok);
    col_mask = sel_b_r ? {1'b1, flags_r.col1_ok, 1'b0}
                       : {1'b1, 1'b1, flags_r.col0_ok};
    cols_in  = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);
    d_nxt    = 4'(rows_in) * 4'(cols_in);
    for (int k = 0; k < NUM_CH; k++) begin
      numer_nxt[k] = (col_mask[0] ? SB'(colsum_r[0][k]) : '0)
                   + (col_mask[1] ? SB'(colsum_r[1][k]) : '0)
                   + SB'(colsum_r[2][k])
                   + SB'(d_nxt >> 1);
    end
  end

  always_comb begin
    case (d_r)
      4'd1:    rcp = (SB+1)'(RCP_1);
      4'd2:    rcp = (SB+1)'(RCP_2);
      4'd3:    rcp = (SB+1)'(RCP_3);
      4'd4:    rcp = (SB+1)'(RCP_4);
      4'd6:    rcp = (SB+1)'(RCP_6);
      4'd9:    rcp = (SB+1)'(RCP_9);
      default: rcp = '0;
    endcase
  end

  // estimate is exact or one low; fix it with the remainder
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      q0[k]      = prod_r[k][PB-1:SB];
      qd[k]      = FW'(q0[k]) * FW'(d_r);
      rem[k]     = FW'(numer_r[k]) - qd[k];
      q1[k]      = (rem[k] >= FW'(d_r)) ? q0[k] + (SB+1)'(1) : q0[k];
      res_nxt[k] = q1[k][CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          flags_r <= h_flags;
          col_r   <= h_col;
          pix_r   <= h_pix;
        end
      end
      ST_SHIFT: begin
        for (int k = 0; k < NUM_CH; k++) begin
          for (int r = 0; r < 3; r++) begin
            win_r[r][0][k] <= win_r[r][1][k];
            win_r[r][1][k] <= win_r[r][2][k];
          end
          win_r[0][2][k] <= older_rd_r[(NUM_CH-1-k)*CB +: CB];
          win_r[1][2][k] <= newer_rd_r[(NUM_CH-1-k)*CB +: CB];
          win_r[2][2][k] <= pix_r[(NUM_CH-1-k)*CB +: CB];
        end
      end
      ST_COLSUM: begin
        sel_b_r <= !flags_r.emit_a;
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < NUM_CH; k++) begin
            colsum_r[j][k] <= (flags_r.top_ok ? CSW'(win_r[0][j][k]) : '0)
                            + CSW'(win_r[1][j][k])
                            + (flags_r.bot_ok ? CSW'(win_r[2][j][k]) : '0);
          end
        end
      end
      ST_ACC: begin
        numer_r <= numer_nxt;
        d_r     <= d_nxt;
      end
      ST_MUL: begin
        for (int k = 0; k < NUM_CH; k++) begin
          prod_r[k] <= PB'(numer_r[k]) * PB'(rcp);
        end
      end
      ST_FIX: begin
        res_r  <= res_nxt;
        last_r <= sel_b_r || !flags_r.emit_b;
        eof_r  <= sel_b_r && flags_r.eof_b;
      end
      ST_OUT: begin
        if (out_fire && more_b) begin
          sel_b_r <= 1'b1;
        end
      end
      default: begin
        sel_b_r <= sel_b_r;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      res_ext[k] = CH_MAX_BITS'(res_r[k]);
    end
  end

  assign out_px.red_out       = res_ext[0][PIX_BITS-1:0];
  assign out_px.green_out     = res_ext[1][PIX_BITS-1:0];
  assign out_px.blue_out      = res_ext[2][PIX_BITS-1:0];
  assign out_px.last_in_burst = last_r;
  assign out_px.end_of_frame  = eof_r;

endmodule

// ----- src/box_blur_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of an RGB frame in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   in_px  : one pixel item per transfer (cmd 0) in raster order; after the
//            last row send image_width drain items (cmd 1) to flush it.
//            A drain item outside the drain phase is dropped.
//   out_px : blurred pixels, one row and one pixel behind the input; the last
//            pixel of a row comes with it, so a row end gives two results.
//            last_in_burst marks the final result of an item, end_of_frame
//            the frame's last pixel.
//   cfg_wr : index 0 = image_width, 1 = image_height; a write restarts the
//            frame. Write only while the block is idle.
// Throughput: the front takes one item per cycle into a two-entry queue
//   while the queue is not full. The back handles one item at a time: line
//   store read and window shift, column sums, then per result the sum,
//   reciprocal multiply, correction and output.
// Reset: 640 x 480, counters cleared; line stores are not cleared.
// Stall: a result holds on out_px until taken; the queue keeps accepting
//   until it is full.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH    = bblur_pkg::MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = bblur_pkg::CHANNEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bblur_in_if.sink     in_px,
  bblur_out_if.source  out_px,
  bblur_cfg_if.sink    cfg_wr
);
  import bblur_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PXW = NUM_CH * CHANNEL_BITS;
  localparam int QW  = $bits(op_flags_t) + CW + PXW;

  logic           push, pop, q_full, q_empty;
  op_flags_t      push_flags, h_flags;
  logic [CW-1:0]  push_col, h_col;
  logic [PXW-1:0] push_pix, h_pix;
  logic [QW-1:0]  q_wdata, q_rdata;

  bblur_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (in_px),
    .cfg_wr     (cfg_wr),
    .q_full     (q_full),
    .push       (push),
    .push_flags (push_flags),
    .push_col   (push_col),
    .push_pix   (push_pix)
  );

  assign q_wdata = {push_flags, push_col, push_pix};

  bblur_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {h_flags, h_col, h_pix} = q_rdata;

  bblur_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (pop),
    .h_flags (h_flags),
    .h_col   (h_col),
    .h_pix   (h_pix),
    .out_px  (out_px)
  );

endmodule
